[hdl/dis_pkg.sv]
// Shared types, constants and functions of the debounced input switch controller.
package dis_pkg;

	// Debounce integrator; the count runs 0 .. DEBOUNCE_LIMIT+1
	localparam int DEBOUNCE_LIMIT = 20;
	localparam int CNT_W = $clog2(DEBOUNCE_LIMIT + 2);
	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t CNT_LIMIT = CNT_W'(DEBOUNCE_LIMIT);

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_ACTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_ACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LED_MODE = 2'd2;

	// Edge action codes
	typedef logic [7:0] action_t;
	localparam action_t ACT_NONE = 8'd0;
	localparam action_t ACT_TOGGLE = 8'd1;
	localparam action_t ACT_ON = 8'd2;
	localparam action_t ACT_OFF = 8'd3;

	// LED modes
	typedef logic [3:0] led_mode_t;
	localparam led_mode_t LED_OFF = 4'd0;
	localparam led_mode_t LED_ON = 4'd1;
	localparam led_mode_t LED_HOLD = 4'd2;
	localparam led_mode_t LED_OUT = 4'd3;
	localparam led_mode_t LED_NOT_OUT = 4'd4;
	localparam led_mode_t LED_IN = 4'd5;
	localparam led_mode_t LED_NOT_IN = 4'd6;
	localparam led_mode_t LED_MANUAL = 4'd7;

	// Edge event codes
	typedef logic [1:0] edge_code_t;
	localparam edge_code_t EDGE_NONE = 2'd0;
	localparam edge_code_t EDGE_PRESS = 2'd1;
	localparam edge_code_t EDGE_RELEASE = 2'd2;

	typedef struct packed {
		action_t   press_action;
		action_t   release_action;
		led_mode_t led_mode;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic pin_level;
		logic toggle_request;
		logic out_write;
		logic out_value;
		logic led_write;
		logic led_value;
	} item_t;

	typedef struct packed {
		cnt_t count;
		logic filtered;
		logic out_state;
		logic led_state;
	} state_t;

	typedef struct packed {
		logic       out_level;
		logic       led_level;
		logic       filtered_level;
		edge_code_t edge_event;
	} result_t;

	function automatic logic apply_action(action_t code, logic level);
		case (code)
			ACT_TOGGLE: apply_action = ~level;
			ACT_ON:     apply_action = 1'b1;
			ACT_OFF:    apply_action = 1'b0;
			default:    apply_action = level;
		endcase
	endfunction

endpackage

[hdl/dis_if.sv]
// Valid/ready channel interfaces for poll words and result words.
interface dis_poll_if;
	logic valid;
	logic ready;
	logic tick;
	logic pin_level;
	logic toggle_request;
	logic out_write;
	logic out_value;
	logic led_write;
	logic led_value;

	modport source (
		output valid, tick, pin_level, toggle_request, out_write, out_value,
		       led_write, led_value,
		input  ready
	);
	modport sink (
		input  valid, tick, pin_level, toggle_request, out_write, out_value,
		       led_write, led_value,
		output ready
	);
endinterface

interface dis_result_if;
	logic       valid;
	logic       ready;
	logic       out_level;
	logic       led_level;
	logic       filtered_level;
	logic [1:0] edge_event;

	modport source (
		output valid, out_level, led_level, filtered_level, edge_event,
		input  ready
	);
	modport sink (
		input  valid, out_level, led_level, filtered_level, edge_event,
		output ready
	);
endinterface

[hdl/dis_step.sv]
// Single-poll update: host writes, debounce, edge action, toggle, LED select.
module dis_step
	import dis_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  st,
	input  item_t   item,
	output state_t  st_nxt,
	output result_t res
);

	logic       out_w;
	logic       led_w;
	logic       filt;
	cnt_t       cnt;
	logic       out_e;
	logic       out_t;
	logic       led_n;
	edge_code_t edge_ev;

	always_comb begin
		out_w = item.out_write ? item.out_value : st.out_state;
		led_w = item.led_write ? item.led_value : st.led_state;

		// up/down integrator, saturating at both ends
		cnt = st.count;
		filt = st.filtered;
		if (item.tick) begin
			if (item.pin_level) begin
				if (st.count > CNT_LIMIT)
					filt = 1'b1;
				else
					cnt = st.count + cnt_t'(1);
			end else begin
				if (st.count == '0)
					filt = 1'b0;
				else
					cnt = st.count - cnt_t'(1);
			end
		end

		// previous filtered level is the stored one
		edge_ev = EDGE_NONE;
		out_e = out_w;
		if (!filt && st.filtered) begin
			edge_ev = EDGE_PRESS;
			out_e = apply_action(cfg.press_action, out_w);
		end else if (filt && !st.filtered) begin
			edge_ev = EDGE_RELEASE;
			out_e = apply_action(cfg.release_action, out_w);
		end

		out_t = out_e ^ item.toggle_request;

		unique case (cfg.led_mode) inside
			LED_ON:               led_n = 1'b1;
			LED_HOLD, LED_MANUAL: led_n = led_w;
			LED_OUT:              led_n = out_t;
			LED_NOT_OUT:          led_n = ~out_t;
			LED_IN:               led_n = filt;
			LED_NOT_IN:           led_n = ~filt;
			default:              led_n = 1'b0;
		endcase

		st_nxt.count = cnt;
		st_nxt.filtered = filt;
		st_nxt.out_state = out_t;
		st_nxt.led_state = led_n;

		res.out_level = out_t;
		res.led_level = led_n;
		res.filtered_level = filt;
		res.edge_event = edge_ev;
	end

endmodule

[hdl/debounced_input_switch_controller.sv]
// Top level: input register, poll update with state, result register.
//
// Usage
//   poll   : sink channel, one word per poll of the switch pin. tick marks a
//            poll on which the debounce timer has elapsed; host writes of the
//            output and the manual LED bit and a toggle request ride along.
//   result : source channel, exactly one word per poll word, in order, with
//            the output level, LED level, debounced level and edge event.
//   cfg_*  : plain write port; index 0 press action, 1 release action,
//            2 LED mode. Write only while no poll word is in flight.
// Path: an accepted poll word is held in the input register, then the
//   state update writes its result word into the result register.
// Throughput: one poll word per cycle while result words are taken; the
//   combinational state update lies between the two registers.
// Stall: when the result word is not taken, the pending poll word waits in
//   the input register; poll ready drops only while both registers are full.
// Reset: arst_n clears both stages, the configuration (all zero: no action,
//   LED off), the debounce count and output/LED state, and sets the filtered
//   level to released.
module debounced_input_switch_controller
	import dis_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dis_poll_if.sink              poll,
	dis_result_if.source          result
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    fire;
	logic    take;

	// stage 2 advances when stage 1 holds a word and the result slot frees
	assign fire = valid_s1 && (!valid_s2 || result.ready);
	assign take = poll.valid && poll.ready;
	assign poll.ready = !valid_s1 || fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS_ACTION:   cfg_q.press_action <= cfg_data;
				REG_RELEASE_ACTION: cfg_q.release_action <= cfg_data;
				REG_LED_MODE:       cfg_q.led_mode <= cfg_data[3:0];
				default:            ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.tick <= poll.tick;
			item_s1.pin_level <= poll.pin_level;
			item_s1.toggle_request <= poll.toggle_request;
			item_s1.out_write <= poll.out_write;
			item_s1.out_value <= poll.out_value;
			item_s1.led_write <= poll.led_write;
			item_s1.led_value <= poll.led_value;
		end
	end

	dis_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// controller state, committed once per poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.count <= '0;
			st_q.filtered <= 1'b1;
			st_q.out_state <= 1'b0;
			st_q.led_state <= 1'b0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_s2 <= res;
	end

	assign result.valid = valid_s2;
	assign result.out_level = res_s2.out_level;
	assign result.led_level = res_s2.led_level;
	assign result.filtered_level = res_s2.filtered_level;
	assign result.edge_event = res_s2.edge_event;

	// count saturates one above the limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= CNT_LIMIT + cnt_t'(1))
		else $error("debounce count out of range");

	// filtered level only moves on a committed poll with tick
	a_filt_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !item_s1.tick) |=> $stable(st_q.filtered))
		else $error("filtered level changed without tick");

	// a press edge reports a pressed level in the same result word
	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.edge_event == EDGE_PRESS) |=>
			(res_s2.filtered_level == 1'b0 && st_q.filtered == 1'b0))
		else $error("press edge with released level");

	// poll backpressure only with both stages full and output stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!poll.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("poll ready dropped without full pipeline");

endmodule
